// ===== rtl/lcwf_pkg.sv =====
// Package of the load cell weigh frame block.
// Types, register indexes, function codes and constants shared by all RTL files.
// No dependencies.
package lcwf_pkg;

   localparam int N_CELLS = 4;

   localparam logic [1:0] FUNC_WEIGH = 2'd0;
   localparam logic [1:0] FUNC_RADIO = 2'd1;
   localparam logic [1:0] FUNC_LINK  = 2'd2;

   localparam logic [2:0] CSR_SLOPE  = 3'd0;
   localparam logic [2:0] CSR_EMPTY  = 3'd1;
   localparam logic [2:0] CSR_STEP   = 3'd2;
   localparam logic [2:0] CSR_SEL_1  = 3'd3;
   localparam logic [2:0] CSR_SEL_2  = 3'd4;
   localparam logic [2:0] CSR_SEL_3  = 3'd5;
   localparam logic [2:0] CSR_SEL_4  = 3'd6;

   localparam logic [31:0] SLOPE_RESET = 32'h0001_0000;

   localparam logic signed [31:0] ALARM_TOTAL  = -32'sd1028;
   localparam logic signed [34:0] SUPPRESS_NEG = -35'sd100;
   localparam logic [39:0]        CENTRE_LIMIT = 40'd100;
   localparam logic signed [40:0] PERCENT      = 41'sd100;

   typedef logic [15:0] word_type;

   typedef struct packed {
      logic signed [31:0] weight;
      logic signed [48:0] raw;
   } lane_result_type;

endpackage

// ===== rtl/lcwf_if.sv =====
// Valid/ready channel interfaces of the load cell weigh frame block.
// Depends on lcwf_pkg.
interface lcwf_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          func;
   lcwf_pkg::word_type  raw_cell_1;
   lcwf_pkg::word_type  raw_cell_2;
   lcwf_pkg::word_type  raw_cell_3;
   lcwf_pkg::word_type  raw_cell_4;

   modport source (output valid, func, raw_cell_1, raw_cell_2, raw_cell_3, raw_cell_4,
                   input ready);
   modport sink (input valid, func, raw_cell_1, raw_cell_2, raw_cell_3, raw_cell_4,
                 output ready);
endinterface

interface lcwf_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  weight_1;
   logic signed [31:0]  weight_2;
   logic signed [31:0]  weight_3;
   logic signed [31:0]  weight_4;
   logic signed [31:0]  total_weight;
   logic signed [7:0]   centre_x;
   logic signed [7:0]   centre_y;
   logic signed [47:0]  raw_sum;
   logic                link_ok;
   logic                radio_ok;
   logic                result_code;

   modport source (output valid, weight_1, weight_2, weight_3, weight_4, total_weight,
                   centre_x, centre_y, raw_sum, link_ok, radio_ok, result_code,
                   input ready);
   modport sink (input valid, weight_1, weight_2, weight_3, weight_4, total_weight,
                 centre_x, centre_y, raw_sum, link_ok, radio_ok, result_code,
                 output ready);
endinterface

// ===== rtl/load_cell_weigh_frame_top.sv =====
// Top level of the load cell weigh frame block: registers, sequencer and merge stage.
// Depends on lcwf_pkg, lcwf_if, lcwf_lane and lcwf_centre.
//
// One transaction at a time. A weight frame runs through the lanes and then the centre
// dividers; the next frame is accepted once the sequencer is back in idle. Four lanes run
// side by side (offset, multiply, 32 one-bit remainder steps, rounding). Then two centre
// dividers run side by side (scale, 40 one-bit quotient steps, clamp). Radio, link error
// and other frames skip the lanes and go straight to the done state. The result waits
// in an output register, so the next transaction is accepted while it is still pending.
module load_cell_weigh_frame_top (
   input  logic        clock,
   input  logic        reset,
   lcwf_req_if.sink    req_chan,
   lcwf_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LANE = 2'd1;
   localparam logic [1:0] ST_CENT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic signed [31:0]  slope_ff;
   logic [15:0]         empty_ff, step_ff;
   logic [2:0]          sel_ff [lcwf_pkg::N_CELLS];

   logic signed [31:0]  w_ff [lcwf_pkg::N_CELLS];
   logic signed [31:0]  total_ff;
   logic signed [7:0]   cx_ff, cy_ff;
   logic signed [47:0]  rsum_ff;
   logic                radio_ff, link_ff, code_ff;
   logic signed [33:0]  exact_ff, nx_ff, ny_ff;
   logic                cent_go_ff;
   logic                rsp_valid_ff;

   lcwf_pkg::word_type        raw [lcwf_pkg::N_CELLS];
   lcwf_pkg::word_type        rd [lcwf_pkg::N_CELLS];
   lcwf_pkg::lane_result_type lane_res [lcwf_pkg::N_CELLS];
   logic [lcwf_pkg::N_CELLS-1:0] lane_done;
   logic                lane_start;
   logic                accept;
   logic                cx_done, cy_done;
   logic signed [7:0]   cx_q, cy_q;
   logic signed [33:0]  exact, nx, ny;
   logic signed [50:0]  rsum;
   logic                load_out;

   assign raw[0] = req_chan.raw_cell_1;
   assign raw[1] = req_chan.raw_cell_2;
   assign raw[2] = req_chan.raw_cell_3;
   assign raw[3] = req_chan.raw_cell_4;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept     = req_chan.valid && req_chan.ready;
   assign lane_start = accept && (req_chan.func == lcwf_pkg::FUNC_WEIGH);

   always_comb begin
      for (int i = 0; i < lcwf_pkg::N_CELLS; i++) begin
         if (sel_ff[i] >= 3'd1 && sel_ff[i] <= 3'd4) begin
            rd[i] = raw[2'(sel_ff[i] - 3'd1)];
         end else begin
            rd[i] = raw[i];
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < lcwf_pkg::N_CELLS; g++) begin : g_lane
         lcwf_lane u_lane (
            .clock  (clock),
            .reset  (reset),
            .start  (lane_start),
            .rd     (rd[g]),
            .empty  (empty_ff),
            .slope  (slope_ff),
            .step   (step_ff),
            .done   (lane_done[g]),
            .result (lane_res[g])
         );
      end
   endgenerate

   assign exact = 34'(lane_res[0].weight) + 34'(lane_res[1].weight)
                + 34'(lane_res[2].weight) + 34'(lane_res[3].weight);
   assign nx    = 34'(lane_res[0].weight) - 34'(lane_res[1].weight)
                - 34'(lane_res[2].weight) + 34'(lane_res[3].weight);
   assign ny    = 34'(lane_res[0].weight) + 34'(lane_res[1].weight)
                - 34'(lane_res[2].weight) - 34'(lane_res[3].weight);
   assign rsum  = 51'(lane_res[0].raw) + 51'(lane_res[1].raw)
                + 51'(lane_res[2].raw) + 51'(lane_res[3].raw);

   lcwf_centre u_centre_x (
      .clock (clock),
      .reset (reset),
      .start (cent_go_ff),
      .num   (nx_ff),
      .den   (exact_ff),
      .done  (cx_done),
      .q     (cx_q)
   );

   lcwf_centre u_centre_y (
      .clock (clock),
      .reset (reset),
      .start (cent_go_ff),
      .num   (ny_ff),
      .den   (exact_ff),
      .done  (cy_done),
      .q     (cy_q)
   );

   assign load_out = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (lane_start) begin
               state_in = ST_LANE;
            end else if (accept) begin
               state_in = ST_DONE;
            end
         end
         ST_LANE: if (&lane_done) state_in = ST_CENT;
         ST_CENT: if (cx_done) state_in = ST_DONE;
         ST_DONE: if (load_out) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slope_ff     <= lcwf_pkg::SLOPE_RESET;
         empty_ff     <= 16'd0;
         step_ff      <= 16'd0;
         for (int i = 0; i < lcwf_pkg::N_CELLS; i++) begin
            sel_ff[i] <= 3'd0;
            w_ff[i]   <= 32'sd0;
         end
         total_ff     <= 32'sd0;
         cx_ff        <= 8'sd0;
         cy_ff        <= 8'sd0;
         rsum_ff      <= 48'sd0;
         radio_ff     <= 1'b0;
         link_ff      <= 1'b0;
         code_ff      <= 1'b1;
         cent_go_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cent_go_ff <= (state_ff == ST_LANE) && (&lane_done);
         if (csr_write_en) begin
            unique case (csr_index)
               lcwf_pkg::CSR_SLOPE: slope_ff  <= csr_data;
               lcwf_pkg::CSR_EMPTY: empty_ff  <= csr_data[15:0];
               lcwf_pkg::CSR_STEP:  step_ff   <= csr_data[15:0];
               lcwf_pkg::CSR_SEL_1: sel_ff[0] <= csr_data[2:0];
               lcwf_pkg::CSR_SEL_2: sel_ff[1] <= csr_data[2:0];
               lcwf_pkg::CSR_SEL_3: sel_ff[2] <= csr_data[2:0];
               lcwf_pkg::CSR_SEL_4: sel_ff[3] <= csr_data[2:0];
               default: ;
            endcase
         end
         if (accept) begin
            code_ff <= 1'b1;
            if (req_chan.func == lcwf_pkg::FUNC_RADIO) begin
               link_ff  <= 1'b1;
               radio_ff <= (req_chan.raw_cell_1 != 16'd0);
            end else if (req_chan.func == lcwf_pkg::FUNC_LINK) begin
               for (int i = 0; i < lcwf_pkg::N_CELLS; i++) begin
                  w_ff[i] <= 32'sd0;
               end
               total_ff <= 32'sd0;
               link_ff  <= 1'b0;
            end
         end
         if ((state_ff == ST_LANE) && (&lane_done)) begin
            for (int i = 0; i < lcwf_pkg::N_CELLS; i++) begin
               w_ff[i] <= lane_res[i].weight;
            end
            total_ff <= exact[31:0];
            rsum_ff  <= rsum[47:0];
            exact_ff <= exact;
            nx_ff    <= nx;
            ny_ff    <= ny;
            link_ff  <= 1'b1;
            code_ff  <= (exact[31:0] == lcwf_pkg::ALARM_TOTAL);
         end
         if ((state_ff == ST_CENT) && cx_done) begin
            cx_ff <= (total_ff == 32'sd0) ? 8'sd0 : cx_q;
            cy_ff <= (total_ff == 32'sd0) ? 8'sd0 : cy_q;
         end
         rsp_valid_ff <= load_out || (rsp_valid_ff && !rsp_chan.ready);
      end
      if (load_out) begin
         rsp_chan.weight_1     <= w_ff[0];
         rsp_chan.weight_2     <= w_ff[1];
         rsp_chan.weight_3     <= w_ff[2];
         rsp_chan.weight_4     <= w_ff[3];
         rsp_chan.total_weight <= total_ff;
         rsp_chan.centre_x     <= cx_ff;
         rsp_chan.centre_y     <= cy_ff;
         rsp_chan.raw_sum      <= rsum_ff;
         rsp_chan.link_ok      <= link_ff;
         rsp_chan.radio_ok     <= radio_ff;
         rsp_chan.result_code  <= code_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;

   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      (&lane_done) == (|lane_done))
      else $error("lanes finished out of step");

   a_centres_agree: assert property (@(posedge clock) disable iff (reset)
      cx_done == cy_done)
      else $error("centre dividers finished out of step");

   a_total_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.total_weight == 32'(rsp_chan.weight_1 + rsp_chan.weight_2
                                                      + rsp_chan.weight_3 + rsp_chan.weight_4))
      else $error("total weight does not match the cell weights");

   a_centre_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.centre_x >= -8'sd100 && rsp_chan.centre_x <= 8'sd100
                         && rsp_chan.centre_y >= -8'sd100 && rsp_chan.centre_y <= 8'sd100)
      else $error("centre of mass out of range");

endmodule

// ===== rtl/lcwf_lane.sv =====
// One cell lane: offset, slope multiply, truncation and step rounding.
// Remainder is found bit-serially, one bit a cycle. Depends on lcwf_pkg.
module lcwf_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  lcwf_pkg::word_type       rd,
   input  lcwf_pkg::word_type       empty,
   input  logic signed [31:0]       slope,
   input  logic [15:0]              step,
   output logic                     done,
   output lcwf_pkg::lane_result_type result
);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_MUL  = 3'd1;
   localparam logic [2:0] PH_ABS  = 3'd2;
   localparam logic [2:0] PH_DIV  = 3'd3;
   localparam logic [2:0] PH_FIN  = 3'd4;

   logic [2:0]         phase_ff, phase_in;
   logic               done_ff;
   logic [16:0]        diff_ff, diff_in;
   logic signed [48:0] prod_ff, prod_in;
   logic [31:0]        mag_ff, mag_in;
   logic signed [32:0] n_ff, n_in;
   logic [15:0]        rem_ff, rem_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [31:0] weight_ff, weight_in;

   logic [48:0]        prod_abs;
   logic [16:0]        t;
   logic [17:0]        sub;
   logic signed [34:0] v;
   logic signed [34:0] p_ext;

   always_comb begin
      phase_in  = phase_ff;
      diff_in   = diff_ff;
      prod_in   = prod_ff;
      mag_in    = mag_ff;
      n_in      = n_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      weight_in = weight_ff;
      prod_abs  = prod_ff[48] ? 49'(-prod_ff) : prod_ff;
      t         = {rem_ff, mag_ff[31]};
      sub       = {1'b0, t} - {2'b0, step};
      p_ext     = $signed({19'd0, step});
      v         = 35'(n_ff) - $signed({19'd0, rem_ff})
                  + ((rem_ff >= (step >> 1)) ? p_ext : 35'sd0);
      if (step == 16'd0) begin
         v = 35'(n_ff);
      end else if (v > 35'sd0 && v <= p_ext + 35'sd1) begin
         v = 35'sd0;
      end else if (v < 35'sd0 && v >= lcwf_pkg::SUPPRESS_NEG) begin
         v = 35'sd0;
      end
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               diff_in  = {1'b0, rd} - {1'b0, empty};
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            prod_in  = slope * $signed(diff_ff);
            phase_in = PH_ABS;
         end
         PH_ABS: begin
            mag_in   = prod_abs[47:16];
            n_in     = prod_ff[48] ? -$signed({1'b0, prod_abs[47:16]})
                                   : $signed({1'b0, prod_abs[47:16]});
            rem_in   = 16'd0;
            cnt_in   = 5'd0;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            rem_in = sub[17] ? t[15:0] : sub[15:0];
            mag_in = {mag_ff[30:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               phase_in = PH_FIN;
            end
         end
         PH_FIN: begin
            weight_in = v[31:0];
            phase_in  = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= (phase_ff == PH_FIN);
      end
      diff_ff   <= diff_in;
      prod_ff   <= prod_in;
      mag_ff    <= mag_in;
      n_ff      <= n_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      weight_ff <= weight_in;
   end

   assign done          = done_ff;
   assign result.weight = weight_ff;
   assign result.raw    = prod_ff;

endmodule

// ===== rtl/lcwf_centre.sv =====
// Centre of mass divider: 100 * num / den, truncated and clamped to +/-100.
// Restoring division, one quotient bit a cycle. Depends on lcwf_pkg.
module lcwf_centre (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [33:0] num,
   input  logic signed [33:0] den,
   output logic               done,
   output logic signed [7:0]  q
);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_SCALE = 2'd1;
   localparam logic [1:0] PH_DIV   = 2'd2;
   localparam logic [1:0] PH_FIN   = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic               done_ff;
   logic signed [33:0] num_ff, num_in, den_ff, den_in;
   logic [39:0]        nmag_ff, nmag_in, quo_ff, quo_in;
   logic [33:0]        dmag_ff, dmag_in, rem_ff, rem_in;
   logic               neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [7:0]  q_ff, q_in;

   logic signed [40:0] scaled;
   logic [40:0]        scaled_abs;
   logic [34:0]        den_abs;
   logic [34:0]        t;
   logic [35:0]        sub;
   logic [6:0]         qc;

   always_comb begin
      phase_in   = phase_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      nmag_in    = nmag_ff;
      dmag_in    = dmag_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      cnt_in     = cnt_ff;
      q_in       = q_ff;
      scaled     = 41'(num_ff) * lcwf_pkg::PERCENT;
      scaled_abs = scaled[40] ? 41'(-scaled) : scaled;
      den_abs    = den_ff[33] ? 35'(-35'(den_ff)) : 35'(den_ff);
      t          = {rem_ff, nmag_ff[39]};
      sub        = {1'b0, t} - {2'b0, dmag_ff};
      qc         = (quo_ff > lcwf_pkg::CENTRE_LIMIT) ? lcwf_pkg::CENTRE_LIMIT[6:0]
                                                     : quo_ff[6:0];
      unique case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               num_in   = num;
               den_in   = den;
               phase_in = PH_SCALE;
            end
         end
         PH_SCALE: begin
            nmag_in  = scaled_abs[39:0];
            dmag_in  = den_abs[33:0];
            neg_in   = num_ff[33] ^ den_ff[33];
            rem_in   = 34'd0;
            quo_in   = 40'd0;
            cnt_in   = 6'd0;
            phase_in = PH_DIV;
         end
         PH_DIV: begin
            rem_in  = sub[35] ? t[33:0] : sub[33:0];
            quo_in  = {quo_ff[38:0], ~sub[35]};
            nmag_in = {nmag_ff[38:0], 1'b0};
            cnt_in  = cnt_ff + 6'd1;
            if (cnt_ff == 6'd39) begin
               phase_in = PH_FIN;
            end
         end
         PH_FIN: begin
            q_in     = neg_ff ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
            phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= (phase_ff == PH_FIN);
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

// ===== tb/sv/tb_load_cell_weigh_frame_top.sv =====
// Self-checking testbench of load_cell_weigh_frame_top: directed frame table, then
// random configuration phases with random frames, both checked by a frame predictor.
// Depends on lcwf_pkg, lcwf_if and the RTL of the block.
module tb_load_cell_weigh_frame_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lcwf_pkg::*;

   localparam logic [1:0] FUNC_NONE = 2'd3;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [31:0] weight[4];
      logic signed [31:0] total_weight;
      logic signed [7:0]  centre_x;
      logic signed [7:0]  centre_y;
      logic signed [47:0] raw_sum;
      logic               link_ok;
      logic               radio_ok;
      logic               result_code;
   } frame_result_t;

   typedef struct {
      bit                 is_csr;
      logic [2:0]         index;
      logic [31:0]        data;
      logic [1:0]         func;
      logic [15:0]        cells[4];
      bit                 fixed;
      logic signed [31:0] total_weight;
      logic               result_code;
   } step_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   lcwf_req_if req_chan();
   lcwf_rsp_if rsp_chan();

   load_cell_weigh_frame_top u_top (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #6 clock = ~clock;

   // predictor copy of the registers and held state
   logic [31:0] slope_reg;
   logic [15:0] empty_reg;
   logic [15:0] step_reg;
   logic [2:0]  select_reg[4];
   frame_result_t held;

   frame_result_t expected_frames[$];
   int fail_count = 0;
   int cycle_count = 0;
   bit fixed_pending = 0;
   logic signed [31:0] fixed_total;
   logic fixed_code;
   bit quiet = 0;
   bit hold_request = 0;

   function automatic logic signed [31:0] round_to_step(longint n);
      longint p, r, v;
      p = longint'(step_reg);
      if (p == 0) return n[31:0];
      r = n % p;
      if (r < 0) r = -r;
      v = (r >= p / 2) ? (n - r + p) : (n - r);
      if (v > 0 && v <= p + 1) v = 0;
      if (v < 0 && v >= -100) v = 0;
      return v[31:0];
   endfunction

   function automatic longint centre_percent(longint num, longint den);
      longint q;
      q = (num * 100) / den;
      if (q > 100) q = 100;
      if (q < -100) q = -100;
      return q;
   endfunction

   function automatic frame_result_t weigh_frame(logic [1:0] func, logic [15:0] cells[4]);
      frame_result_t res;
      logic [15:0] rd[4];
      longint slope_s, rw, rsum, exact, nx, ny, q;
      res = held;
      res.result_code = 1'b1;
      if (func == FUNC_WEIGH) begin
         slope_s = longint'(signed'(slope_reg));
         rsum = 0;
         exact = 0;
         for (int i = 0; i < 4; i++)
            rd[i] = (select_reg[i] >= 1 && select_reg[i] <= 4) ? cells[select_reg[i] - 1]
                                                                : cells[i];
         for (int i = 0; i < 4; i++) begin
            rw = slope_s * (longint'(rd[i]) - longint'(empty_reg));
            rsum += rw;
            res.weight[i] = round_to_step(rw / 65536);
            exact += longint'(res.weight[i]);
         end
         res.total_weight = exact[31:0];
         res.raw_sum = rsum[47:0];
         if (res.total_weight != 0) begin
            nx = longint'(res.weight[0]) - res.weight[1] - res.weight[2] + res.weight[3];
            ny = longint'(res.weight[0]) + res.weight[1] - res.weight[2] - res.weight[3];
            q = centre_percent(nx, exact);
            res.centre_x = q[7:0];
            q = centre_percent(ny, exact);
            res.centre_y = q[7:0];
         end else begin
            res.centre_x = '0;
            res.centre_y = '0;
         end
         res.link_ok = 1'b1;
         res.result_code = (res.total_weight != ALARM_TOTAL) ? 1'b0 : 1'b1;
      end else if (func == FUNC_RADIO) begin
         res.link_ok = 1'b1;
         res.radio_ok = (cells[0] != 0);
      end else if (func == FUNC_LINK) begin
         for (int i = 0; i < 4; i++) res.weight[i] = '0;
         res.total_weight = '0;
         res.link_ok = 1'b0;
      end
      held = res;
      held.result_code = 1'b0;
      return res;
   endfunction

   function automatic void check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // predict on each accepted request transaction
   always @(posedge clock) begin
      logic [15:0] cells[4];
      frame_result_t exp_r;
      if (!reset && req_chan.valid && req_chan.ready) begin
         cells[0] = req_chan.raw_cell_1;
         cells[1] = req_chan.raw_cell_2;
         cells[2] = req_chan.raw_cell_3;
         cells[3] = req_chan.raw_cell_4;
         exp_r = weigh_frame(req_chan.func, cells);
         if (fixed_pending) begin
            exp_r.total_weight = fixed_total;
            exp_r.result_code = fixed_code;
         end
         expected_frames.push_back(exp_r);
      end
   end

   // compare each accepted result transaction
   always @(posedge clock) begin
      frame_result_t e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_frames.size() == 0) begin
            $error("result transaction with no expectation waiting");
            fail_count++;
         end else begin
            e = expected_frames.pop_front();
            check_field("weight_1", e.weight[0], rsp_chan.weight_1);
            check_field("weight_2", e.weight[1], rsp_chan.weight_2);
            check_field("weight_3", e.weight[2], rsp_chan.weight_3);
            check_field("weight_4", e.weight[3], rsp_chan.weight_4);
            check_field("total_weight", e.total_weight, rsp_chan.total_weight);
            check_field("centre_x", e.centre_x, rsp_chan.centre_x);
            check_field("centre_y", e.centre_y, rsp_chan.centre_y);
            check_field("raw_sum", e.raw_sum, rsp_chan.raw_sum);
            check_field("link_ok", e.link_ok, rsp_chan.link_ok);
            check_field("radio_ok", e.radio_ok, rsp_chan.radio_ok);
            check_field("result_code", e.result_code, rsp_chan.result_code);
         end
      end
   end

   // receiver: random stall bursts, one long hold-off on request
   always @(negedge clock) begin
      static int stall_left = 0;
      if (hold_request) begin
         stall_left = 400;
         hold_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 12) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance, valid high
   task automatic send_frame(logic [1:0] func, logic [15:0] cells[4]);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.func <= func;
      req_chan.raw_cell_1 <= cells[0];
      req_chan.raw_cell_2 <= cells[1];
      req_chan.raw_cell_3 <= cells[2];
      req_chan.raw_cell_4 <= cells[3];
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] data);
      req_chan.valid <= 1'b0;
      while (expected_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_SLOPE: slope_reg = data;
         CSR_EMPTY: empty_reg = data[15:0];
         CSR_STEP:  step_reg = data[15:0];
         CSR_SEL_1: select_reg[0] = data[2:0];
         CSR_SEL_2: select_reg[1] = data[2:0];
         CSR_SEL_3: select_reg[2] = data[2:0];
         CSR_SEL_4: select_reg[3] = data[2:0];
         default: ;
      endcase
   endtask

   function automatic logic [15:0] random_reading();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] random_slope();
      logic [31:0] s;
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return SLOPE_RESET;
         3: return 32'h0;
         4: return $urandom;
         default: begin
            s = $urandom_range(0, 1 << 20);
            return $urandom_range(0, 1) ? -s : s;
         end
      endcase
   endfunction

   function automatic logic [31:0] random_step();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF;
         2: return $urandom_range(0, 65535);
         default: return $urandom_range(1, 200);
      endcase
   endfunction

   step_row_t frame_table[] = '{
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, 262140, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'h0001, 16'h0000, 16'h0000, 16'h0000}, 1, 1, 0},
      '{0, CSR_SLOPE, 0, FUNC_RADIO, '{16'h0000, 16'h1234, 16'h0000, 16'h0000}, 1, 1, 1},
      '{0, CSR_SLOPE, 0, FUNC_RADIO, '{16'h8000, 16'h0000, 16'h0000, 16'h0000}, 1, 1, 1},
      '{0, CSR_SLOPE, 0, FUNC_LINK,  '{16'h1111, 16'h2222, 16'h3333, 16'h4444}, 1, 0, 1},
      '{0, CSR_SLOPE, 0, FUNC_NONE,  '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 1, 0, 1},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'd100, 16'd200, 16'd300, 16'd400}, 0, 0, 0},
      '{1, CSR_EMPTY, 257, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1, -1028, 1},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'd257, 16'd257, 16'd257, 16'd257}, 1, 0, 0},
      '{1, CSR_STEP, 10, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'd300, 16'd262, 16'd250, 16'd1000}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'd200, 16'd150, 16'd268, 16'd263}, 0, 0, 0},
      '{1, CSR_STEP, 65535, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000}, 0, 0, 0},
      '{1, CSR_SLOPE, 32'h8000_0000, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'h0000, 16'hFFFF, 16'h1234, 16'hFFFF}, 0, 0, 0},
      '{1, CSR_SLOPE, 32'h7FFF_FFFF, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{1, CSR_STEP, 0, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'hFFFF, 16'h0000, 16'h0101, 16'h7FFF}, 0, 0, 0},
      '{1, CSR_SEL_1, 4, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{1, CSR_SEL_2, 1, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{1, CSR_SEL_3, 7, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{1, CSR_SEL_4, 3, FUNC_WEIGH, '{16'h0, 16'h0, 16'h0, 16'h0}, 0, 0, 0},
      '{0, CSR_SLOPE, 0, FUNC_WEIGH, '{16'd1000, 16'd2000, 16'd3000, 16'd4000}, 0, 0, 0}
   };

   initial begin
      logic [15:0] cells[4];
      logic [1:0] func;
      int pick;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_WEIGH;
      req_chan.raw_cell_1 = '0;
      req_chan.raw_cell_2 = '0;
      req_chan.raw_cell_3 = '0;
      req_chan.raw_cell_4 = '0;
      rsp_chan.ready = 1'b0;
      slope_reg = SLOPE_RESET;
      empty_reg = '0;
      step_reg = '0;
      for (int i = 0; i < 4; i++) begin
         select_reg[i] = '0;
         held.weight[i] = '0;
      end
      held.total_weight = '0;
      held.centre_x = '0;
      held.centre_y = '0;
      held.raw_sum = '0;
      held.link_ok = 1'b0;
      held.radio_ok = 1'b0;
      held.result_code = 1'b0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (frame_table[k]) begin
         if (frame_table[k].is_csr) begin
            write_register(frame_table[k].index, frame_table[k].data);
         end else begin
            fixed_pending = frame_table[k].fixed;
            fixed_total = frame_table[k].total_weight;
            fixed_code = frame_table[k].result_code;
            send_frame(frame_table[k].func, frame_table[k].cells);
            fixed_pending = 0;
         end
      end

      for (int phase = 0; phase < 8; phase++) begin
         write_register(CSR_SLOPE, random_slope());
         pick = $urandom_range(0, 3);
         write_register(CSR_EMPTY, pick == 0 ? 32'h0 : pick == 1 ? 32'hFFFF
                                                : $urandom_range(0, 65535));
         write_register(CSR_STEP, random_step());
         for (int i = 0; i < 4; i++)
            write_register(CSR_SEL_1 + 3'(i),
                           $urandom_range(0, 1) ? 32'h0 : $urandom_range(0, 7));
         if (phase == 7) quiet = 1;
         for (int n = 0; n < 250; n++) begin
            if (phase == 2 && n == 20) hold_request = 1;
            pick = $urandom_range(0, 19);
            func = pick < 15 ? FUNC_WEIGH : pick < 17 ? FUNC_RADIO
                 : pick < 19 ? FUNC_LINK : FUNC_NONE;
            for (int i = 0; i < 4; i++) cells[i] = random_reading();
            send_frame(func, cells);
         end
      end
      req_chan.valid <= 1'b0;

      while (expected_frames.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
